[hw/rtl/tft_pkg.sv]
// Shared types and constants for the TCP flow tracker.
`default_nettype none
package tft_pkg;
    localparam int PendingDepthDefault = 16;
    localparam logic [15:0] EphMinReset = 16'd49152;
    localparam logic [8:0] GainReset = 9'd32;
    localparam logic [0:0] CfgEphMin = 1'b0;
    localparam logic [0:0] CfgGain = 1'b1;

    typedef enum logic [3:0] {
        ST_UNKNOWN = 4'd0, ST_SYN_SENT = 4'd1, ST_SYN_RCVD = 4'd2, ST_ESTAB = 4'd3,
        ST_FIN_WAIT1 = 4'd4, ST_FIN_WAIT2 = 4'd5, ST_CLOSING = 4'd6,
        ST_TIME_WAIT = 4'd7, ST_CLOSE_WAIT = 4'd8, ST_LAST_ACK = 4'd9,
        ST_CLOSED = 4'd10
    } tcp_state_t;

    typedef struct packed {
        logic        is_client;
        logic [31:0] seq;
        logic [31:0] ack;
        logic [15:0] plen;
        logic [62:0] now;
        logic [3:0]  cstate;
        logic [3:0]  sstate;
        logic [47:0] dsent;
        logic [47:0] drecv;
        logic [47:0] wsent;
        logic [47:0] wrecv;
    } front_item_t;

    function automatic logic [47:0] add_sat48(input logic [47:0] c, input logic [15:0] v);
        logic [48:0] s;
        s = {1'b0, c} + {33'd0, v};
        return s[48] ? {48{1'b1}} : s[47:0];
    endfunction

    function automatic logic [3:0] advance(input logic [7:0] f, input logic [3:0] s);
        logic [3:0] n;
        n = s;
        if (f[0]) begin
            if (s == ST_ESTAB) n = ST_FIN_WAIT1;
            else if (s == ST_FIN_WAIT1) n = ST_CLOSING;
            else if (s == ST_CLOSE_WAIT) n = ST_LAST_ACK;
        end
        if (f[4]) begin
            if (n == ST_FIN_WAIT1) n = ST_FIN_WAIT2;
            else if (n == ST_CLOSING) n = ST_TIME_WAIT;
            else if (n == ST_LAST_ACK) n = ST_CLOSED;
        end
        return n;
    endfunction
endpackage
`default_nettype wire

[hw/rtl/tft_front.sv]
// Front end: role inference, connection state machine and byte counters.
`default_nettype none
module tft_front (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [15:0] eph_min,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] sport,
    input  wire logic [15:0] dst_port,
    input  wire logic [7:0]  tcp_flags,
    input  wire logic [31:0] seq_in,
    input  wire logic [31:0] ack_in,
    input  wire logic [15:0] plen_in,
    input  wire logic [15:0] wlen_in,
    input  wire logic [62:0] timestamp_us,
    output logic             q_valid,
    input  wire logic        q_ready,
    output tft_pkg::front_item_t q_item
);
    logic seen_reg;
    logic [15:0] cport_reg;
    logic [3:0] cst_reg, sst_reg;
    logic [47:0] cnt_reg [4];
    logic q_valid_reg;
    tft_pkg::front_item_t q_item_reg;

    logic [15:0] cport_next;
    logic [3:0] cst_next, sst_next, snd, rcv;
    logic fc;
    logic syn, ackf;

    assign in_ready = !q_valid_reg || q_ready;
    assign q_valid = q_valid_reg;
    assign q_item = q_item_reg;
    assign syn = tcp_flags[1];
    assign ackf = tcp_flags[4];

    always_comb begin
        cport_next = cport_reg;
        cst_next = cst_reg;
        sst_next = sst_reg;
        snd = cst_reg;
        rcv = sst_reg;
        if (!seen_reg) begin
            if (syn && ackf) begin
                cport_next = dst_port;
                cst_next = tft_pkg::ST_ESTAB; sst_next = tft_pkg::ST_ESTAB;
            end else if (syn) begin
                cport_next = sport;
                cst_next = tft_pkg::ST_SYN_SENT; sst_next = tft_pkg::ST_SYN_RCVD;
            end else if (ackf) begin
                if (sport >= eph_min && !(dst_port >= eph_min)) cport_next = sport;
                else cport_next = dst_port;
                cst_next = tft_pkg::ST_ESTAB; sst_next = tft_pkg::ST_ESTAB;
            end
        end else begin
            if (sport == cport_reg) begin
                snd = cst_reg; rcv = sst_reg;
            end else begin
                snd = sst_reg; rcv = cst_reg;
            end
            if ((snd == tft_pkg::ST_SYN_SENT && syn && ackf) ||
                (snd == tft_pkg::ST_SYN_RCVD && ackf)) begin
                snd = tft_pkg::ST_ESTAB; rcv = tft_pkg::ST_ESTAB;
            end else begin
                snd = tft_pkg::advance(tcp_flags, snd);
                if (tcp_flags[2]) begin
                    snd = tft_pkg::ST_CLOSED; rcv = tft_pkg::ST_CLOSED;
                end
            end
            if (sport == cport_reg) begin
                cst_next = snd; sst_next = rcv;
            end else begin
                cst_next = rcv; sst_next = snd;
            end
        end
        fc = (sport == cport_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
            cport_reg <= '0;
            cst_reg <= tft_pkg::ST_UNKNOWN;
            sst_reg <= tft_pkg::ST_UNKNOWN;
            for (int i = 0; i < 4; i++) cnt_reg[i] <= '0;
            q_valid_reg <= 1'b0;
        end else begin
            q_valid_reg <= (in_valid && in_ready) || (q_valid_reg && !q_ready);
            if (in_valid && in_ready) begin
                seen_reg <= 1'b1;
                cport_reg <= cport_next;
                cst_reg <= cst_next;
                sst_reg <= sst_next;
                if (fc) begin
                    cnt_reg[0] <= tft_pkg::add_sat48(cnt_reg[0], plen_in);
                    cnt_reg[2] <= tft_pkg::add_sat48(cnt_reg[2], wlen_in);
                end else begin
                    cnt_reg[1] <= tft_pkg::add_sat48(cnt_reg[1], plen_in);
                    cnt_reg[3] <= tft_pkg::add_sat48(cnt_reg[3], wlen_in);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            q_item_reg.is_client <= fc;
            q_item_reg.seq <= seq_in;
            q_item_reg.ack <= ack_in;
            q_item_reg.plen <= plen_in;
            q_item_reg.now <= timestamp_us;
            q_item_reg.cstate <= cst_next;
            q_item_reg.sstate <= sst_next;
            q_item_reg.dsent <= fc ? tft_pkg::add_sat48(cnt_reg[0], plen_in) : cnt_reg[0];
            q_item_reg.drecv <= fc ? cnt_reg[1] : tft_pkg::add_sat48(cnt_reg[1], plen_in);
            q_item_reg.wsent <= fc ? tft_pkg::add_sat48(cnt_reg[2], wlen_in) : cnt_reg[2];
            q_item_reg.wrecv <= fc ? cnt_reg[3] : tft_pkg::add_sat48(cnt_reg[3], wlen_in);
        end
    end

`ifndef SYNTHESIS
    a_seen: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> seen_reg) else $error("seen not set");
    a_qv: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid && in_ready) |=> q_valid_reg) else $error("queue entry lost");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_valid_reg && !q_ready) |=> q_valid_reg) else $error("entry dropped");
`endif
endmodule
`default_nettype wire

[hw/rtl/tft_back.sv]
// Back end: expected-ack ring, retransmission check and RTT estimator.
`default_nettype none
module tft_back #(
    parameter int PENDING_DEPTH = tft_pkg::PendingDepthDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [8:0]  gain,
    input  wire logic        q_valid,
    output logic             q_ready,
    input  wire tft_pkg::front_item_t q_item,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_client_state,
    output logic [3:0]       m_server_state,
    output logic             m_from_client,
    output logic             m_retransmitted,
    output logic [31:0]      m_rtt_last_us,
    output logic [39:0]      m_rtt_smoothed,
    output logic [47:0]      m_data_bytes_sent,
    output logic [47:0]      m_data_bytes_received,
    output logic [47:0]      m_wire_bytes_sent,
    output logic [47:0]      m_wire_bytes_received,
    output logic [31:0]      m_retransmission_count,
    output logic             m_queue_overflow
);
    localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int CW = $clog2(PENDING_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001, S_CHECK = 6'b000010, S_POPRD = 6'b000100,
        S_POPCMP = 6'b001000, S_MUL = 6'b010000, S_OUT = 6'b100000
    } bstate_t;

    bstate_t st_reg;
    logic [31:0] ackmem [PENDING_DEPTH];
    logic [62:0] timemem [PENDING_DEPTH];
    logic [AW-1:0] head_reg, tail_reg;
    logic [CW-1:0] count_reg;
    tft_pkg::front_item_t it_reg;
    logic [31:0] rd_ack_reg, nw_ack_reg;
    logic [62:0] rd_time_reg;
    logic [31:0] last_rtt_reg, rcnt_reg;
    logic [39:0] srtt_reg;
    logic [31:0] samp_reg;
    logic [48:0] mul_a_reg, mul_b_reg;
    logic retr_reg, ovf_reg, m_valid_reg;
    logic [AW-1:0] newest;
    logic [63:0] diff;
    logic [31:0] sample;
    logic [8:0] g;
    logic [49:0] mix;

    assign q_ready = (st_reg == S_IDLE) && !m_valid_reg;
    assign newest = (tail_reg == '0) ? AW'(PENDING_DEPTH - 1) : tail_reg - AW'(1);
    assign diff = {1'b0, it_reg.now} - {1'b0, rd_time_reg};
    assign sample = diff[63] ? 32'd0 : ((|diff[62:32]) ? 32'hFFFF_FFFF : diff[31:0]);
    assign g = (gain > 9'd256) ? 9'd256 : gain;
    assign mix = {1'b0, mul_a_reg} + {1'b0, mul_b_reg} + 50'd128;

    always_ff @(posedge aclk) begin
        if (st_reg == S_CHECK && it_reg.plen != 16'd0 && count_reg != CW'(PENDING_DEPTH)) begin
            ackmem[tail_reg] <= it_reg.seq + {16'd0, it_reg.plen};
            timemem[tail_reg] <= it_reg.now;
        end
        rd_ack_reg <= ackmem[head_reg];
        rd_time_reg <= timemem[head_reg];
        nw_ack_reg <= ackmem[newest];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE;
            head_reg <= '0; tail_reg <= '0; count_reg <= '0;
            last_rtt_reg <= '0; srtt_reg <= '0; rcnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (st_reg)
                S_IDLE: begin
                    if (m_ready) m_valid_reg <= 1'b0;
                    if (q_valid && q_ready) st_reg <= S_CHECK;
                end
                S_CHECK: begin
                    retr_reg <= (count_reg != '0) && (it_reg.seq < nw_ack_reg);
                    ovf_reg <= (it_reg.plen != 16'd0) && (count_reg == CW'(PENDING_DEPTH));
                    if (count_reg != '0 && it_reg.seq < nw_ack_reg &&
                        rcnt_reg != 32'hFFFF_FFFF) rcnt_reg <= rcnt_reg + 32'd1;
                    if (it_reg.plen != 16'd0 && count_reg != CW'(PENDING_DEPTH)) begin
                        tail_reg <= (tail_reg == AW'(PENDING_DEPTH - 1)) ? '0
                                    : tail_reg + AW'(1);
                        count_reg <= count_reg + CW'(1);
                    end
                    st_reg <= S_POPRD;
                end
                S_POPRD: st_reg <= S_POPCMP;
                S_POPCMP: begin
                    if (count_reg != '0 && it_reg.ack >= rd_ack_reg) begin
                        last_rtt_reg <= sample;
                        samp_reg <= sample;
                        mul_a_reg <= 49'(9'd256 - g) * 49'(srtt_reg);
                        mul_b_reg <= 49'(g) * {9'd0, sample, 8'd0};
                        head_reg <= (head_reg == AW'(PENDING_DEPTH - 1)) ? '0
                                    : head_reg + AW'(1);
                        count_reg <= count_reg - CW'(1);
                        st_reg <= S_MUL;
                    end else st_reg <= S_OUT;
                end
                S_MUL: begin
                    if (srtt_reg == '0) srtt_reg <= {samp_reg, 8'd0};
                    else srtt_reg <= mix[47:8];
                    st_reg <= S_POPRD;
                end
                S_OUT: begin
                    m_valid_reg <= 1'b1;
                    st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) it_reg <= q_item;
    end

    assign m_valid = m_valid_reg;
    assign m_client_state = it_reg.cstate;
    assign m_server_state = it_reg.sstate;
    assign m_from_client = it_reg.is_client;
    assign m_retransmitted = retr_reg;
    assign m_rtt_last_us = last_rtt_reg;
    assign m_rtt_smoothed = srtt_reg;
    assign m_data_bytes_sent = it_reg.dsent;
    assign m_data_bytes_received = it_reg.drecv;
    assign m_wire_bytes_sent = it_reg.wsent;
    assign m_wire_bytes_received = it_reg.wrecv;
    assign m_retransmission_count = rcnt_reg;
    assign m_queue_overflow = ovf_reg;

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(PENDING_DEPTH)) else $error("ring count overrun");
    a_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != CW'(PENDING_DEPTH) && count_reg != '0) |-> (head_reg != tail_reg))
        else $error("ring pointers inconsistent");
    a_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_OUT) |=> m_valid_reg) else $error("result lost");
`endif
endmodule
`default_nettype wire

[hw/rtl/tcp_flow_tracker.sv]
// Top level of the TCP flow tracker.
`default_nettype none
// One TCP flow, one segment per transaction, one result per segment. A front
// stage infers roles, steps the connection state machines and counts bytes,
// and holds the segment in a one-entry queue; a back stage then checks
// retransmission, pushes the expected ack of a segment with payload into a
// PENDING_DEPTH ring while it has room and retires acknowledged entries with an
// RTT/EWMA update each. The back stage steps through check and push, ring read,
// compare and result for each segment, plus ring read, compare and multiply for
// each retired entry, and takes the next segment only after its result has been
// accepted. Write configuration only when idle.
module tcp_flow_tracker #(
    parameter int PENDING_DEPTH = tft_pkg::PendingDepthDefault
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_src_port,
    input  wire logic [15:0] s_dst_port,
    input  wire logic [7:0]  s_tcp_flags,
    input  wire logic [31:0] s_seq_number,
    input  wire logic [31:0] s_ack_number,
    input  wire logic [15:0] s_payload_length,
    input  wire logic [15:0] s_wire_length,
    input  wire logic [62:0] s_timestamp_us,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [3:0]       m_client_state,
    output logic [3:0]       m_server_state,
    output logic             m_from_client,
    output logic             m_retransmitted,
    output logic [31:0]      m_rtt_last_us,
    output logic [39:0]      m_rtt_smoothed,
    output logic [47:0]      m_data_bytes_sent,
    output logic [47:0]      m_data_bytes_received,
    output logic [47:0]      m_wire_bytes_sent,
    output logic [47:0]      m_wire_bytes_received,
    output logic [31:0]      m_retransmission_count,
    output logic             m_queue_overflow
);
    logic [15:0] eph_reg;
    logic [8:0] gain_reg;
    logic q_valid, q_ready;
    tft_pkg::front_item_t q_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eph_reg <= tft_pkg::EphMinReset;
            gain_reg <= tft_pkg::GainReset;
        end else if (cfg_we) begin
            if (cfg_index == tft_pkg::CfgEphMin) eph_reg <= cfg_data;
            else gain_reg <= cfg_data[8:0];
        end
    end

    tft_front u_front (
        .aclk, .aresetn, .eph_min(eph_reg),
        .in_valid(s_valid), .in_ready(s_ready),
        .sport(s_src_port), .dst_port(s_dst_port), .tcp_flags(s_tcp_flags),
        .seq_in(s_seq_number), .ack_in(s_ack_number),
        .plen_in(s_payload_length), .wlen_in(s_wire_length),
        .timestamp_us(s_timestamp_us),
        .q_valid, .q_ready, .q_item
    );

    tft_back #(.PENDING_DEPTH(PENDING_DEPTH)) u_back (
        .aclk, .aresetn, .gain(gain_reg),
        .q_valid, .q_ready, .q_item,
        .m_valid, .m_ready, .m_client_state, .m_server_state, .m_from_client,
        .m_retransmitted, .m_rtt_last_us, .m_rtt_smoothed, .m_data_bytes_sent,
        .m_data_bytes_received, .m_wire_bytes_sent, .m_wire_bytes_received,
        .m_retransmission_count, .m_queue_overflow
    );
endmodule
`default_nettype wire
